[rtl/core/tseq_pkg.sv]
// tseq_pkg: shared types, command and result codes for the event queue
// no dependencies
package tseq_pkg;

	localparam int DefQueueDepth = 32;
	localparam int DefTimeWidth  = 32;
	localparam logic [15:0] DEFAULT_TPB = 16'd96;

	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_RESUME = 3'd2;
	localparam logic [2:0] CMD_FREEZE = 3'd3;
	localparam logic [2:0] CMD_JUMP   = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	localparam logic [1:0] KIND_RELEASE = 2'd0;
	localparam logic [1:0] KIND_EMPTIED = 2'd1;
	localparam logic [1:0] KIND_PASS    = 2'd2;
	localparam logic [1:0] KIND_REJECT  = 2'd3;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_INSERT,
		OP_CLEAR
	} op_t;

	// outputs of one result item
	typedef struct packed {
		logic        strobe;
		logic [1:0]  kind;
		logic [31:0] tag;
		logic        last;
	} res_t;

endpackage

[rtl/core/tseq_front.sv]
// tseq_front: accepts commands, keeps time, beat position and freeze,
// and hands classified ops to the back part through a short queue; uses tseq_pkg
module tseq_front import tseq_pkg::*; #(
	parameter int TIME_WIDTH = DefTimeWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            cmd,
	input  logic [23:0]           delay_ticks,
	input  logic [31:0]           payload,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_data,
	input  logic                  q_full,
	input  logic                  q_empty,
	input  logic                  back_idle,
	output logic                  busy,
	output logic                  push,
	output op_t                   push_op,
	output logic [TIME_WIDTH-1:0] push_time,
	output logic                  push_imm,
	output logic [31:0]           push_tag
);

	logic [TIME_WIDTH-1:0] now_q;
	logic [15:0]           tib_q;
	logic [15:0]           tpb_q;
	logic                  frozen_q;
	logic [15:0]           tpb_eff;
	logic [15:0]           tib_inc;
	logic [15:0]           adv;
	logic [TIME_WIDTH-1:0] now_jump;
	logic                  acc;

	assign tpb_eff = (tpb_q == 16'd0) ? DEFAULT_TPB : tpb_q;
	// ops are taken one at a time: the next waits until the back is done
	assign busy = !q_empty || !back_idle || push;
	assign acc  = start && !busy;
	assign tib_inc = tib_q + 16'd1;
	assign adv = (tib_q < tpb_eff) ? (tpb_eff - tib_q) : 16'd1;
	assign now_jump = now_q + TIME_WIDTH'(adv);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q <= DEFAULT_TPB;
		end else if (cfg_we) begin
			tpb_q <= cfg_data;
		end
	end

	// command decode and time keeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			tib_q    <= '0;
			frozen_q <= 1'b0;
			push     <= 1'b0;
			push_op  <= OP_TICK;
			push_time <= '0;
			push_imm <= 1'b0;
			push_tag <= '0;
		end else begin
			push <= 1'b0;
			if (acc && !q_full) begin
				push_tag <= payload;
				push_imm <= 1'b0;
				case (cmd)
					CMD_TICK, CMD_RESUME: begin
						if (cmd == CMD_RESUME) frozen_q <= 1'b0;
						now_q <= now_q + 1'b1;
						tib_q <= (tib_inc >= tpb_eff) ? 16'd0 : tib_inc;
						push_time <= now_q + 1'b1;
						push_op <= OP_TICK;
						push <= (cmd == CMD_RESUME) || !frozen_q;
					end
					CMD_JUMP: begin
						frozen_q <= 1'b0;
						now_q <= now_jump + 1'b1;
						tib_q <= (16'd1 >= tpb_eff) ? 16'd0 : 16'd1;
						push_time <= now_jump + 1'b1;
						push_op <= OP_TICK;
						push <= 1'b1;
					end
					CMD_INSERT: begin
						push_op <= OP_INSERT;
						push_imm <= (delay_ticks == 24'd0);
						push_time <= now_q + TIME_WIDTH'(delay_ticks);
						push <= 1'b1;
					end
					CMD_FREEZE: begin
						frozen_q <= 1'b1;
					end
					CMD_CLEAR: begin
						push_op <= OP_CLEAR;
						push <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

[rtl/core/tseq_fifo.sv]
// tseq_fifo: two-entry queue of ops between front and back
// uses tseq_pkg
module tseq_fifo import tseq_pkg::*; #(
	parameter int TIME_WIDTH = DefTimeWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  op_t                   push_op,
	input  logic [TIME_WIDTH-1:0] push_time,
	input  logic                  push_imm,
	input  logic [31:0]           push_tag,
	input  logic                  pop,
	output logic                  full,
	output logic                  empty,
	output op_t                   head_op,
	output logic [TIME_WIDTH-1:0] head_time,
	output logic                  head_imm,
	output logic [31:0]           head_tag
);

	localparam int W = 2 + TIME_WIDTH + 1 + 32;
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic [W-1:0] hd;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign hd = mem_q[rp_q];
	assign head_op   = op_t'(hd[W-1 -: 2]);
	assign head_time = hd[W-3 -: TIME_WIDTH];
	assign head_imm  = hd[32];
	assign head_tag  = hd[31:0];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= {push_op, push_time, push_imm, push_tag};
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= !wp_q;
			if (pop && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

[rtl/core/tseq_back.sv]
// tseq_back: sorted entry store; shifts one entry per cycle for insert,
// releases one due entry per cycle on tick; uses tseq_pkg
module tseq_back import tseq_pkg::*; #(
	parameter int QUEUE_DEPTH = DefQueueDepth,
	parameter int TIME_WIDTH  = DefTimeWidth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  op_t                   head_op,
	input  logic [TIME_WIDTH-1:0] head_time,
	input  logic                  head_imm,
	input  logic [31:0]           head_tag,
	output logic                  pop,
	output logic                  idle,
	output res_t                  res
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REL,
		S_SHIFT
	} state_t;

	state_t                state_q;
	logic [TIME_WIDTH-1:0] due_q [QUEUE_DEPTH];
	logic [31:0]           tag_q [QUEUE_DEPTH];
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         pos_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] ins_t_q;
	logic [31:0]           ins_tag_q;
	logic                  due0;
	logic                  ge_prev;
	logic [TIME_WIDTH-1:0] d0, dp;
	logic [IW-1:0]         pi, pm;

	assign d0 = now_q - due_q[0];
	assign due0 = !d0[TIME_WIDTH-1];
	assign pi = pos_q[IW-1:0];
	assign pm = IW'(pos_q - 1'b1);
	// previous entry due at or after the new one: shift continues
	assign dp = due_q[pm] - ins_t_q;
	assign ge_prev = !dp[TIME_WIDTH-1];
	assign idle = (state_q == S_IDLE) && !pop;

	// control, shifting store and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pos_q <= '0;
			pop <= 1'b0;
			res <= '0;
		end else begin
			pop <= 1'b0;
			res <= '0;
			case (state_q)
				S_IDLE: begin
					if (!q_empty && !pop) begin
						pop <= 1'b1;
						case (head_op)
							OP_CLEAR: cnt_q <= '0;
							OP_TICK: begin
								now_q <= head_time;
								state_q <= S_REL;
							end
							OP_INSERT: begin
								if (head_imm) begin
									res <= '{strobe: 1'b1, kind: KIND_PASS, tag: head_tag,
										last: 1'b1};
								end else if (cnt_q >= CW'(QUEUE_DEPTH)) begin
									res <= '{strobe: 1'b1, kind: KIND_REJECT, tag: 32'd0,
										last: 1'b1};
								end else begin
									ins_t_q <= head_time;
									ins_tag_q <= head_tag;
									pos_q <= cnt_q;
									state_q <= S_SHIFT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_REL: begin
					if (cnt_q != '0 && due0) begin
						for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
							due_q[i] <= due_q[i+1];
							tag_q[i] <= tag_q[i+1];
						end
						cnt_q <= cnt_q - 1'b1;
						res <= '{strobe: 1'b1, kind: KIND_RELEASE, tag: tag_q[0],
							last: 1'b0};
						if (cnt_q == CW'(1)) state_q <= S_SHIFT;
						if (cnt_q == CW'(1)) pos_q <= '1;
					end else begin
						// last flag goes on the previous release
						state_q <= S_IDLE;
					end
				end
				S_SHIFT: begin
					if (pos_q == '1) begin
						res <= '{strobe: 1'b1, kind: KIND_EMPTIED, tag: 32'd0,
							last: 1'b1};
						state_q <= S_IDLE;
					end else if (pos_q != '0 && ge_prev) begin
						due_q[pi] <= due_q[pm];
						tag_q[pi] <= tag_q[pm];
						pos_q <= pos_q - 1'b1;
					end else begin
						due_q[pi] <= ins_t_q;
						tag_q[pi] <= ins_tag_q;
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/tick_scheduled_event_queue_core.sv]
// tick_scheduled_event_queue_core: top level, front, op queue and back
// depends on tseq_pkg, tseq_front, tseq_fifo, tseq_back
//
// channel   | signals                                 | handshake
// command   | cmd, delay_ticks, payload               | start && !busy
// result    | kind, event_tag, last                   | strobe, one cycle
// config    | cfg_we, cfg_data (ticks_per_beat)       | cfg_we
//
// an insert shifts the entries it passes one per cycle (up to QUEUE_DEPTH - 1);
// a tick releases due entries one per cycle.
// the single-port shifting entry store sets these rates.
// reset clears time, freeze and count; entries need no clearing.
// the receiver cannot stall: results leave as they are made.
module tick_scheduled_event_queue_core import tseq_pkg::*; #(
	parameter int QUEUE_DEPTH = DefQueueDepth,
	parameter int TIME_WIDTH  = DefTimeWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [23:0] delay_ticks,
	input  logic [31:0] payload,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [31:0] event_tag,
	output logic        last
);

	logic                  push, push_imm, q_full, q_empty, pop, back_idle;
	op_t                   push_op, head_op;
	logic [TIME_WIDTH-1:0] push_time, head_time;
	logic [31:0]           push_tag, head_tag;
	logic                  head_imm;
	res_t                  res;
	res_t                  hold_q;

	tseq_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
		.clk, .arst_n, .start, .cmd, .delay_ticks, .payload, .cfg_we, .cfg_data,
		.q_full, .q_empty, .back_idle, .busy, .push, .push_op, .push_time,
		.push_imm, .push_tag
	);

	tseq_fifo #(.TIME_WIDTH(TIME_WIDTH)) u_fifo (
		.clk, .arst_n, .push, .push_op, .push_time, .push_imm, .push_tag, .pop,
		.full(q_full), .empty(q_empty), .head_op, .head_time, .head_imm, .head_tag
	);

	tseq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_WIDTH(TIME_WIDTH)) u_back (
		.clk, .arst_n, .q_empty, .head_op, .head_time, .head_imm, .head_tag,
		.pop, .idle(back_idle), .res
	);

	// one-deep hold so a release learns whether it is the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			strobe <= 1'b0;
			kind <= '0;
			event_tag <= '0;
			last <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (hold_q.strobe && (res.strobe || back_idle)) begin
				strobe <= 1'b1;
				kind <= hold_q.kind;
				event_tag <= hold_q.tag;
				last <= hold_q.last || (!res.strobe) ||
					(res.kind != KIND_RELEASE && res.kind != KIND_EMPTIED);
			end
			if (res.strobe) hold_q <= res;
			else if (hold_q.strobe && back_idle) hold_q <= '0;
		end
	end

endmodule
